FILE: rtl/ddm_pkg.sv
// shared constants and helpers for the decimal digit multiplier
// no dependencies
package ddm_pkg;

  localparam int unsigned DigitW   = 4;
  localparam int unsigned MaxDigit = 9;
  localparam int unsigned MaxProd  = MaxDigit * MaxDigit;

  // x / 10 == (x * DivRecip) >> DivShift for x below 43690
  localparam int unsigned DivRecip = 52429;
  localparam int unsigned DivShift = 19;

  function automatic logic [DigitW-1:0] clamp_digit(logic [DigitW-1:0] d);
    logic [DigitW-1:0] res;
    res = (d > DigitW'(MaxDigit)) ? DigitW'(MaxDigit) : d;
    return res;
  endfunction

endpackage

FILE: rtl/ddm_digit_store.sv
// factor digit memories, one write port and one registered read port each
// depends on ddm_pkg
module ddm_digit_store #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic [ddm_pkg::DigitW-1:0]    wdata_a_i,
  input  logic [ddm_pkg::DigitW-1:0]    wdata_b_i,
  input  logic                          re_i,
  input  logic [AW-1:0]                 raddr_a_i,
  input  logic [AW-1:0]                 raddr_b_i,
  output logic [ddm_pkg::DigitW-1:0]    rdata_a_o,
  output logic [ddm_pkg::DigitW-1:0]    rdata_b_o
);

  logic [ddm_pkg::DigitW-1:0] mem_a_q [DEPTH];
  logic [ddm_pkg::DigitW-1:0] mem_b_q [DEPTH];
  logic [ddm_pkg::DigitW-1:0] rdata_a_q;
  logic [ddm_pkg::DigitW-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_a_q[waddr_i] <= wdata_a_i;
      mem_b_q[waddr_i] <= wdata_b_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_a_q[raddr_a_i];
      rdata_b_q <= mem_b_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: rtl/ddm_result_store.sv
// product digit memory, one write port and one registered read port
// depends on ddm_pkg
module ddm_result_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic [ddm_pkg::DigitW-1:0]    wdata_i,
  input  logic                          re_i,
  input  logic [AW-1:0]                 raddr_i,
  output logic [ddm_pkg::DigitW-1:0]    rdata_o
);

  logic [ddm_pkg::DigitW-1:0] mem_q [DEPTH];
  logic [ddm_pkg::DigitW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ddm_div10.sv
// shared divide-by-ten unit: quotient by reciprocal multiply, remainder by shift-add
// depends on ddm_pkg
module ddm_div10 #(
  parameter int unsigned W = 13
) (
  input  logic [W-1:0]               x_i,
  output logic [W-1:0]               q_o,
  output logic [ddm_pkg::DigitW-1:0] r_o
);

  localparam int unsigned PrW = W + 16;

  logic [PrW-1:0] prod_w;
  logic [W-1:0]   q_w;
  logic [W+3:0]   q10_w;
  logic [W+3:0]   diff_w;

  assign prod_w = PrW'(x_i) * PrW'(ddm_pkg::DivRecip);
  assign q_w    = W'(prod_w >> ddm_pkg::DivShift);
  assign q10_w  = ((W+4)'(q_w) << 3) + ((W+4)'(q_w) << 1);
  assign diff_w = (W+4)'(x_i) - q10_w;

  assign q_o = q_w;
  assign r_o = diff_w[ddm_pkg::DigitW-1:0];

endmodule

FILE: rtl/decimal_digit_multiplier.sv
// top level of the decimal digit multiplier: sequencer, accumulator and stream ports
// depends on ddm_pkg, ddm_digit_store, ddm_result_store, ddm_div10
//
// Digit pairs are taken one per cycle, most significant first, until tlast or
// MAX_DIGITS pairs; the block then drops tready and works column by column from
// the least significant one, with a single 4x4 multiply-accumulate fed from the
// factor memories and one shared divide-by-ten unit that both splits each column
// sum and ripples the carry. The multiply-accumulate visits every digit product
// once; the 2n product digits then leave at one per cycle while the sink is ready.
module decimal_digit_multiplier #(
  parameter int unsigned MAX_DIGITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // digit_a [3:0], digit_b [7:4]
  input  logic       s_axis_tlast,   // last_pair
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // product_digit [3:0], zero fill [7:4]
  output logic       m_axis_tlast    // last_digit
);

  localparam int unsigned DW = ddm_pkg::DigitW;
  localparam int unsigned AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned NW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned CW = $clog2(2 * MAX_DIGITS);
  localparam int unsigned SW = $clog2(MAX_DIGITS * ddm_pkg::MaxProd + 1);
  localparam int unsigned PW = SW + 1;

  localparam logic [3:0] ST_LOAD  = 4'd0;
  localparam logic [3:0] ST_INIT  = 4'd1;
  localparam logic [3:0] ST_MAC   = 4'd2;
  localparam logic [3:0] ST_DRAIN = 4'd3;
  localparam logic [3:0] ST_DIVS  = 4'd4;
  localparam logic [3:0] ST_PADD  = 4'd5;
  localparam logic [3:0] ST_DIVP  = 4'd6;
  localparam logic [3:0] ST_WTOP  = 4'd7;
  localparam logic [3:0] ST_EMIT  = 4'd8;

  logic [3:0]    state_q, state_d;
  logic [NW-1:0] n_q, n_d;
  logic [CW-1:0] c_q, c_d;
  logic [AW-1:0] i_q, i_d;
  logic [AW-1:0] j_q, j_d;
  logic          v1_q, v1_d;
  logic [SW-1:0] acc_q, acc_d;
  logic [SW-1:0] sq_q, sq_d;
  logic [DW-1:0] sr_q, sr_d;
  logic [SW-1:0] prevq_q, prevq_d;
  logic [SW-1:0] rc_q, rc_d;
  logic [PW-1:0] p_q, p_d;
  logic [DW-1:0] tens_q, tens_d;
  logic [NW:0]   pos_q, pos_d;
  logic          ov_q, ov_d;
  logic          olast_q, olast_d;

  logic          in_acc;
  logic [NW-1:0] n_inc;
  logic          ends;
  logic [CW:0]   cx, nx, ilo_w, ihi_w, j_w;
  logic [NW:0]   total;

  logic          dig_re;
  logic [DW-1:0] dig_a, dig_b;
  logic [7:0]    prod_w;

  logic          res_we;
  logic [CW-1:0] res_waddr;
  logic [DW-1:0] res_wdata;
  logic          res_re;
  logic [DW-1:0] res_rdata;

  logic [PW-1:0] div_x;
  logic [PW-1:0] div_q;
  logic [DW-1:0] div_r;

  assign s_axis_tready = (state_q == ST_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign n_inc         = n_q + NW'(1);
  assign ends          = s_axis_tlast || (n_inc == NW'(MAX_DIGITS));

  // term range of the current column
  assign cx    = (CW+1)'(c_q);
  assign nx    = (CW+1)'(n_q);
  assign ilo_w = (cx >= nx - (CW+1)'(1)) ? cx - (nx - (CW+1)'(1)) : '0;
  assign ihi_w = (cx < nx) ? cx : nx - (CW+1)'(1);
  assign j_w   = cx - ilo_w;
  assign total = {n_q, 1'b0};

  assign prod_w = 8'(dig_a) * 8'(dig_b);
  assign div_x  = (state_q == ST_DIVP) ? p_q : PW'(acc_q);

  ddm_digit_store #(
    .DEPTH (MAX_DIGITS),
    .AW    (AW)
  ) u_digits (
    .clk_i     (clk_i),
    .we_i      (in_acc),
    .waddr_i   (n_q[AW-1:0]),
    .wdata_a_i (ddm_pkg::clamp_digit(s_axis_tdata[3:0])),
    .wdata_b_i (ddm_pkg::clamp_digit(s_axis_tdata[7:4])),
    .re_i      (dig_re),
    .raddr_a_i (i_q),
    .raddr_b_i (j_q),
    .rdata_a_o (dig_a),
    .rdata_b_o (dig_b)
  );

  ddm_div10 #(
    .W (PW)
  ) u_div10 (
    .x_i (div_x),
    .q_o (div_q),
    .r_o (div_r)
  );

  ddm_result_store #(
    .DEPTH (2 * MAX_DIGITS),
    .AW    (CW)
  ) u_result (
    .clk_i   (clk_i),
    .we_i    (res_we),
    .waddr_i (res_waddr),
    .wdata_i (res_wdata),
    .re_i    (res_re),
    .raddr_i (pos_q[CW-1:0]),
    .rdata_o (res_rdata)
  );

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    c_d       = c_q;
    i_d       = i_q;
    j_d       = j_q;
    v1_d      = 1'b0;
    acc_d     = v1_q ? acc_q + SW'(prod_w) : acc_q;
    sq_d      = sq_q;
    sr_d      = sr_q;
    prevq_d   = prevq_q;
    rc_d      = rc_q;
    p_d       = p_q;
    tens_d    = tens_q;
    pos_d     = pos_q;
    ov_d      = ov_q;
    olast_d   = olast_q;
    dig_re    = 1'b0;
    res_we    = 1'b0;
    res_waddr = c_q + CW'(1);
    res_wdata = div_r;
    res_re    = 1'b0;

    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          n_d = n_inc;
          if (ends) begin
            c_d     = CW'({n_q, 1'b0});
            rc_d    = '0;
            prevq_d = '0;
            state_d = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        i_d     = ilo_w[AW-1:0];
        j_d     = j_w[AW-1:0];
        acc_d   = '0;
        state_d = ST_MAC;
      end
      ST_MAC: begin
        dig_re = 1'b1;
        v1_d   = 1'b1;
        if (i_q == ihi_w[AW-1:0]) begin
          state_d = ST_DRAIN;
        end else begin
          i_d = i_q + AW'(1);
          j_d = j_q - AW'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_DIVS;
      end
      ST_DIVS: begin
        sq_d    = div_q[SW-1:0];
        sr_d    = div_r;
        state_d = ST_PADD;
      end
      ST_PADD: begin
        // the top column keeps its whole sum
        p_d     = ((c_q != '0) ? PW'(sr_q) : PW'(acc_q)) + PW'(prevq_q) + PW'(rc_q);
        state_d = ST_DIVP;
      end
      ST_DIVP: begin
        res_we  = 1'b1;
        rc_d    = div_q[SW-1:0];
        prevq_d = sq_q;
        if (c_q == '0) begin
          tens_d  = (div_q > PW'(ddm_pkg::MaxDigit)) ? DW'(ddm_pkg::MaxDigit) : div_q[DW-1:0];
          state_d = ST_WTOP;
        end else begin
          c_d     = c_q - CW'(1);
          state_d = ST_INIT;
        end
      end
      ST_WTOP: begin
        res_we    = 1'b1;
        res_waddr = '0;
        res_wdata = tens_q;
        pos_d     = '0;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (pos_q != total) begin
          res_re = !ov_q || m_axis_tready;
        end else if (!ov_q || m_axis_tready) begin
          n_d     = '0;
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase

    // output register fed straight from the result read port
    if (res_re) begin
      ov_d    = 1'b1;
      olast_d = (pos_q == total - (NW+1)'(1));
      pos_d   = pos_q + (NW+1)'(1);
    end else if (m_axis_tready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      n_q     <= '0;
      v1_q    <= 1'b0;
      ov_q    <= 1'b0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      v1_q    <= v1_d;
      ov_q    <= ov_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q     <= c_d;
    i_q     <= i_d;
    j_q     <= j_d;
    acc_q   <= acc_d;
    sq_q    <= sq_d;
    sr_q    <= sr_d;
    prevq_q <= prevq_d;
    rc_q    <= rc_d;
    p_q     <= p_d;
    tens_q  <= tens_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {4'b0000, res_rdata};
  assign m_axis_tlast  = olast_q;

endmodule

FILE: rtl/ddm_checker.sv
// port-level checks for the decimal digit multiplier, bound to the top level
// depends on decimal_digit_multiplier
module ddm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // a stalled output transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled output transaction changed");

  // loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a product digit is pending");

  // product digits are decimal with zero fill
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[3:0] <= 4'd9) && (m_axis_tdata[7:4] == 4'd0)))
    else $error("product digit out of range");

  // a final pair starts the multiply and closes the input
  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input still ready after the final pair");

endmodule

bind decimal_digit_multiplier ddm_checker u_ddm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: verif/testbench.sv
// testbench for decimal_digit_multiplier: streams digit pairs in, checks product digits out
// depends on ddm_pkg and the decimal_digit_multiplier rtl; holds its own product predictor
`timescale 1ns / 100ps

localparam int unsigned MaxPairs = 32;
localparam int unsigned Radix    = 10;

typedef struct packed {
  logic [ddm_pkg::DigitW-1:0] digit;
  logic                       last;
} product_digit_t;

class product_scoreboard;
  logic [ddm_pkg::DigitW-1:0] a_digits[MaxPairs];
  logic [ddm_pkg::DigitW-1:0] b_digits[MaxPairs];
  int unsigned                pairs_loaded;
  product_digit_t             expected_q[$];
  int unsigned                mismatches;
  int unsigned                digits_checked;
  int unsigned                products;
  int unsigned                longest;

  function new();
    pairs_loaded   = 0;
    mismatches     = 0;
    digits_checked = 0;
    products       = 0;
    longest        = 0;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  // accepted input transaction: store the pair, predict the product when the load ends
  function void note_pair(logic [3:0] a, logic [3:0] b, logic last);
    logic [3:0]  col_digit[2*MaxPairs];
    logic [8:0]  col_carry[2*MaxPairs];
    logic [8:0]  carry;
    int unsigned n, ncols, sum, top, p, tens;
    int          c;
    product_digit_t item;
    a_digits[pairs_loaded] = (a > ddm_pkg::MaxDigit) ? 4'(ddm_pkg::MaxDigit) : a;
    b_digits[pairs_loaded] = (b > ddm_pkg::MaxDigit) ? 4'(ddm_pkg::MaxDigit) : b;
    pairs_loaded++;
    if (!last && pairs_loaded < MaxPairs) return;
    n     = pairs_loaded;
    ncols = 2 * n - 1;
    top   = 0;
    col_carry[ncols-1] = '0;
    // crosswise column sums, most significant column first
    for (c = 0; c < int'(ncols); c++) begin
      sum = 0;
      for (int i = 0; i < int'(n); i++)
        if (c >= i && c - i < int'(n)) sum += a_digits[i] * b_digits[c-i];
      if (c != 0) begin
        col_carry[c-1] = 9'(sum / Radix);
        col_digit[c]   = 4'(sum % Radix);
      end else begin
        top = sum;
      end
    end
    // carry ripple from the least significant column
    carry = '0;
    for (c = int'(ncols) - 1; c >= 0; c--) begin
      p     = ((c != 0) ? col_digit[c] : top) + col_carry[c] + carry;
      carry = 9'(p / Radix);
      if (c != 0) col_digit[c] = 4'(p % Radix);
      else top = p;
    end
    tens = top / Radix;
    item.digit = 4'((tens > ddm_pkg::MaxDigit) ? ddm_pkg::MaxDigit : tens);
    item.last  = 1'b0;
    expected_q.push_back(item);
    item.digit = 4'(top % Radix);
    item.last  = (ncols == 1);
    expected_q.push_back(item);
    for (c = 1; c < int'(ncols); c++) begin
      item.digit = col_digit[c];
      item.last  = (c == int'(ncols) - 1);
      expected_q.push_back(item);
    end
    products++;
    if (n > longest) longest = n;
    pairs_loaded = 0;
  endfunction

  // accepted output transaction against the oldest predicted digit
  function void check_digit(logic [3:0] digit, logic last);
    product_digit_t want;
    digits_checked++;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected product digit %0d last %0b", digit, last);
      return;
    end
    want = expected_q.pop_front();
    if (want.digit !== digit || want.last !== last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("digit %0d: expected %0d last %0b, got %0d last %0b",
                 digits_checked, want.digit, want.last, digit, last);
    end
  endfunction
endclass

module testbench;

  localparam int unsigned SinkHoldCycles = 400;
  localparam int unsigned DrainCycles    = 100;
  localparam int unsigned RandomItems    = 54;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;   // digit_a [3:0], digit_b [7:4]
  logic       s_axis_tlast  = 1'b0; // last_pair
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;         // product_digit [3:0], zero fill [7:4]
  logic       m_axis_tlast;         // last_digit

  product_scoreboard sb;
  bit                steady;
  bit                sink_hold_req;

  decimal_digit_multiplier #(.MAX_DIGITS(MaxPairs)) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [3:0] rand_digit();
    if ($urandom_range(0, 4) == 0) return 4'($urandom_range(10, 15));
    return 4'($urandom_range(0, 9));
  endfunction

  task automatic push_pair(input logic [3:0] a, input logic [3:0] b, input logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_pair(a, b, last);
  endtask

  task automatic wait_for_products();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // sink side: random stalls, one long hold-off on request
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (SinkHoldCycles) @(posedge clk_i);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_digit(m_axis_tdata[3:0], m_axis_tlast);
  end

  initial begin
    #400000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned items;
    int unsigned job;
    int unsigned n;
    sb = new();
    @(posedge rst_ni);
    @(posedge clk_i);

    // single pairs and short multi-pair loads, clamping and all-nines
    push_pair(4'd0, 4'd0, 1'b1);
    push_pair(4'd9, 4'd9, 1'b1);
    push_pair(4'd15, 4'd15, 1'b1);
    push_pair(4'd10, 4'd3, 1'b1);
    push_pair(4'd7, 4'd12, 1'b1);
    push_pair(4'd9, 4'd9, 1'b0);
    push_pair(4'd9, 4'd9, 1'b1);
    push_pair(4'd15, 4'd0, 1'b0);
    push_pair(4'd0, 4'd15, 1'b0);
    push_pair(4'd11, 4'd13, 1'b1);
    push_pair(4'd8, 4'd1, 1'b0);
    push_pair(4'd4, 4'd2, 1'b0);
    push_pair(4'd2, 4'd4, 1'b0);
    push_pair(4'd1, 4'd8, 1'b1);

    // full-capacity load, the 32nd pair ends it whatever tlast says
    for (int k = 0; k < int'(MaxPairs); k++)
      push_pair(rand_digit(), rand_digit(),
                (k == int'(MaxPairs) - 1) ? 1'($urandom_range(0, 1)) : 1'b0);

    items = 0;
    job   = 0;
    while (items < RandomItems || job <= 6) begin
      if (job == 2) sink_hold_req = 1'b1;
      if (job == 6) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        wait_for_products();
      end
      steady = (job >= 8 && job < 12);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
      for (int k = 0; k < int'(n); k++)
        push_pair(rand_digit(), rand_digit(), k == int'(n) - 1);
      items += n;
      job++;
    end
    s_axis_tvalid <= 1'b0;
    steady = 1'b0;

    wait_for_products();
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d products checked, %0d digits, factor lengths 1 to %0d, %0d mismatches",
             sb.products, sb.digits_checked, sb.longest, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/ddm_pkg.sv
rtl/ddm_digit_store.sv
rtl/ddm_result_store.sv
rtl/ddm_div10.sv
rtl/decimal_digit_multiplier.sv
rtl/ddm_checker.sv
verif/testbench.sv
